// ----- design/byte_deque_with_search_top_assert.svh -----
// Assertion macros for the byte deque with search.
`ifndef BYTE_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH
`define BYTE_DEQUE_WITH_SEARCH_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BDQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Condition that must hold on the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bdq_pkg.sv -----
// Request and status codes for the byte deque with search.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_FIND       = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	localparam int unsigned IDX_FIELD_W = 6;
	localparam int unsigned CNT_FIELD_W = 7;

endpackage

`default_nettype wire

// ----- design/byte_deque_with_search_top.sv -----
// Byte deque with search: ring store in a synchronous memory, front pointer and count.
// Push, clear and unused codes report from the execute state; pops report from the pop state after the
// memory read, or from the execute state when empty. Find reads one stored entry per cycle in the scan state.
// One transaction in flight; busy falls with the done strobe, results cannot be stalled.
// Reset clears front pointer and count; memory contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_deque_with_search_top_assert.svh"

module byte_deque_with_search_top
	import bdq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output      logic                   busy,
	input  wire logic [2:0]             req_type,
	input  wire logic [7:0]             item_byte,
	output      logic                   done,
	output      logic [7:0]             out_byte,
	output      logic [IDX_FIELD_W-1:0] found_index,
	output      logic [CNT_FIELD_W-1:0] fill_count,
	output      logic [1:0]             status
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SCAN
	} state_t;

	state_t             state_q;
	logic [2:0]         req_q;
	logic [7:0]         byte_q;
	logic [PTR_W-1:0]   front_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PTR_W-1:0]   scan_q;
	logic [PTR_W-1:0]   scan_ptr_q;
	logic               done_q;
	logic [7:0]         out_byte_q;
	logic [IDX_FIELD_W-1:0] found_index_q;
	logic [CNT_FIELD_W-1:0] fill_count_q;
	status_t            status_q;

	logic [7:0]         mem [DEPTH];
	logic [7:0]         rd_data_s1;

	logic               full;
	logic               empty;
	logic [PTR_W-1:0]   front_dec;
	logic [PTR_W-1:0]   front_inc;
	logic [PTR_W-1:0]   scan_ptr_inc;
	logic [SUM_W-1:0]   tail_sum;
	logic [SUM_W-1:0]   last_sum;
	logic [PTR_W-1:0]   tail_pos;
	logic [PTR_W-1:0]   last_pos;
	logic               scan_last;
	logic               wr_en;
	logic [PTR_W-1:0]   wr_addr;
	logic               rd_en;
	logic [PTR_W-1:0]   rd_addr;
	logic               is_push;
	logic               is_pop;

	function automatic logic [CNT_FIELD_W-1:0] cnt_field(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[CNT_FIELD_W-1:0];
	endfunction

	function automatic logic [IDX_FIELD_W-1:0] idx_field(input logic [PTR_W-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[IDX_FIELD_W-1:0];
	endfunction

	always_comb begin
		full         = (cnt_q == CNT_W'(DEPTH));
		empty        = (cnt_q == '0);
		front_dec    = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - PTR_W'(1);
		front_inc    = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + PTR_W'(1);
		scan_ptr_inc = (scan_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : scan_ptr_q + PTR_W'(1);
		tail_sum     = SUM_W'(front_q) + SUM_W'(cnt_q);
		last_sum     = tail_sum - SUM_W'(1);
		tail_pos     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
		                                           : PTR_W'(tail_sum);
		last_pos     = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
		                                           : PTR_W'(last_sum);
		scan_last    = ((CNT_W'(scan_q) + CNT_W'(1)) == cnt_q);
		is_push      = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
		is_pop       = (req_q == REQ_POP_FRONT) || (req_q == REQ_POP_BACK);

		wr_en   = (state_q == S_EXEC) && is_push && !full;
		wr_addr = (req_q == REQ_PUSH_FRONT) ? front_dec : tail_pos;

		rd_en   = ((state_q == S_EXEC) && !empty && (is_pop || (req_q == REQ_FIND)))
		          || (state_q == S_SCAN);
		rd_addr = front_q;
		if (state_q == S_SCAN) begin
			rd_addr = scan_ptr_inc;
		end else if (req_q == REQ_POP_BACK) begin
			rd_addr = last_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= byte_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			req_q         <= '0;
			byte_q        <= '0;
			front_q       <= '0;
			cnt_q         <= '0;
			scan_q        <= '0;
			scan_ptr_q    <= '0;
			done_q        <= 1'b0;
			out_byte_q    <= '0;
			found_index_q <= '0;
			fill_count_q  <= '0;
			status_q      <= STAT_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req_type;
						byte_q  <= item_byte;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					out_byte_q    <= '0;
					found_index_q <= '0;
					fill_count_q  <= cnt_field(cnt_q);
					status_q      <= STAT_OK;
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
					case (req_q)
						REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
							if (full) begin
								status_q <= STAT_FULL;
							end else begin
								if (req_q == REQ_PUSH_FRONT) begin
									front_q <= front_dec;
								end
								cnt_q        <= cnt_q + CNT_W'(1);
								fill_count_q <= cnt_field(cnt_q + CNT_W'(1));
							end
						end
						REQ_POP_FRONT, REQ_POP_BACK: begin
							if (empty) begin
								status_q <= STAT_EMPTY;
							end else begin
								if (req_q == REQ_POP_FRONT) begin
									front_q <= front_inc;
								end
								cnt_q   <= cnt_q - CNT_W'(1);
								done_q  <= 1'b0;
								state_q <= S_POP;
							end
						end
						REQ_FIND: begin
							if (empty) begin
								status_q <= STAT_NOT_FOUND;
							end else begin
								scan_q     <= '0;
								scan_ptr_q <= front_q;
								done_q     <= 1'b0;
								state_q    <= S_SCAN;
							end
						end
						REQ_CLEAR: begin
							front_q      <= '0;
							cnt_q        <= '0;
							fill_count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					out_byte_q    <= rd_data_s1;
					found_index_q <= '0;
					fill_count_q  <= cnt_field(cnt_q);
					status_q      <= STAT_OK;
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
				end
				S_SCAN: begin
					if (rd_data_s1 == byte_q) begin
						out_byte_q    <= '0;
						found_index_q <= idx_field(scan_q);
						fill_count_q  <= cnt_field(cnt_q);
						status_q      <= STAT_OK;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else if (scan_last) begin
						out_byte_q    <= '0;
						found_index_q <= '0;
						fill_count_q  <= cnt_field(cnt_q);
						status_q      <= STAT_NOT_FOUND;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						scan_q     <= scan_q + PTR_W'(1);
						scan_ptr_q <= scan_ptr_inc;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign out_byte    = out_byte_q;
	assign found_index = found_index_q;
	assign fill_count  = fill_count_q;
	assign status      = status_q;

	`BDQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "count exceeds depth")
	`BDQ_ASSERT_ALWAYS(a_done_idle, !done_q || !busy, "result strobe while busy")
	`BDQ_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe longer than one cycle")
	`BDQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_q, "accepted transaction not busy")
	`BDQ_ASSERT_ALWAYS(a_no_write_busy_scan, !(wr_en && (state_q == S_SCAN)), "write during scan")

endmodule

`default_nettype wire
